FILE: rtl/gedge_pkg.sv
// shared types and constants for the gradient edge threshold block
package gedge_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 12;
  localparam int ROW_W      = 16;
  localparam int TH_W       = 8;
  localparam int SQ_W       = 16;
  localparam int MAG_W      = 17;
  localparam int LIM_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // decoupling queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

  // reset values of the configuration
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
  localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 16'd480;
  localparam int               EDGE_TH_RST      = 32;
  localparam logic [LIM_W-1:0] LIM_RST          = LIM_W'(4 * EDGE_TH_RST * EDGE_TH_RST);

  // output pixel codes for interior pixels
  localparam logic [PIX_W-1:0] PIX_EDGE = 8'd0;
  localparam logic [PIX_W-1:0] PIX_FLAT = 8'd255;

  // one queued job: up to two results caused by one input pixel
  typedef struct packed {
    logic [PIX_W-1:0] res;
    logic [PIX_W-1:0] pix;
    logic             emit_res;
    logic             emit_pix;
  } job_t;

  // a queue slot as seen on push or at the head
  typedef struct packed {
    logic valid;
    job_t job;
  } qslot_t;

  // width that holds both the register value and the line buffer depth
  function automatic int width_bits(input int max_width);
    int b;
    b = $clog2(max_width + 1);
    return (b > FW_W) ? b : FW_W;
  endfunction

endpackage

FILE: rtl/gedge_if.sv
// stream and configuration interfaces of the gradient edge threshold block
interface gedge_in_if;
  import gedge_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma;
  modport source (output valid, output luma, input ready);
  modport sink (input valid, input luma, output ready);
endinterface

interface gedge_out_if;
  import gedge_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             run_last;
  modport source (output valid, output pixel_out, output run_last, input ready);
  modport sink (input valid, input pixel_out, input run_last, output ready);
endinterface

interface gedge_cfg_if;
  import gedge_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/gedge_front.sv
// front: raster counters, line buffers and gradient test pipeline
module gedge_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int WW        = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gedge_pkg::PIX_W-1:0] in_luma,
  input  logic [WW-1:0]               eff_w,
  input  logic [gedge_pkg::ROW_W-1:0] eff_h,
  input  logic [gedge_pkg::LIM_W-1:0] lim,
  input  logic [gedge_pkg::QCW-1:0]   q_count,
  output gedge_pkg::qslot_t           q_push
);
  import gedge_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // line buffers
  logic [PIX_W-1:0] line_prev  [MAX_WIDTH];
  logic [PIX_W-1:0] line_prev2 [MAX_WIDTH];

  logic [AW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;

  // stage 1 registers
  logic             s1_valid_r;
  logic [AW-1:0]    s1_col_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_emit_res_r, s1_emit_pix_r, s1_border_r;
  logic             byp_c_r, byp_r_r;
  logic [PIX_W-1:0] byp_pix_r, byp_ctr_r;
  logic [PIX_W-1:0] lp_c_q, lp_r_q, lp2_q;
  logic [PIX_W-1:0] displaced_r;

  // stage 2 registers
  logic             s2_valid_r;
  logic [PIX_W-1:0] s2_ctr_r, s2_pix_r;
  logic [SQ_W-1:0]  s2_sqx_r, s2_sqy_r;
  logic             s2_emit_res_r, s2_emit_pix_r, s2_border_r;

  logic             accept;
  logic [QCW-1:0]   occupancy;
  logic             wrap0, wrap1, last_row;
  logic [AW-1:0]    c0, a_r, col_nxt;
  logic [ROW_W-1:0] r_pre, r0, row_nxt;
  logic [WW-1:0]    c_plus;
  logic [ROW_W:0]   r0_p1;

  // credit check: queue entries plus items in flight must leave a free slot
  assign occupancy = q_count + QCW'(s1_valid_r) + QCW'(s2_valid_r);
  assign in_ready  = occupancy < QCW'(QDEPTH);
  assign accept    = in_valid && in_ready;

  // position of this pixel and of the next one
  always_comb begin
    wrap0    = WW'(col_r) >= eff_w;
    c0       = wrap0 ? '0 : col_r;
    r_pre    = wrap0 ? (row_r + 16'd1) : row_r;
    r0       = (r_pre >= eff_h) ? '0 : r_pre;
    c_plus   = WW'(c0) + WW'(1);
    a_r      = c_plus[AW-1:0];
    wrap1    = c_plus >= eff_w;
    r0_p1    = {1'b0, r0} + 17'd1;
    last_row = r0_p1 >= {1'b0, eff_h};
    col_nxt  = wrap1 ? '0 : c_plus[AW-1:0];
    row_nxt  = wrap1 ? (last_row ? '0 : r0_p1[ROW_W-1:0]) : r0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1 values with bypass of the write landing at the read edge
  logic [PIX_W-1:0] center, right, up2;
  logic signed [PIX_W:0]   dx, dy;
  logic signed [2*PIX_W+1:0] prod_x, prod_y;

  always_comb begin
    center = byp_c_r ? byp_pix_r : lp_c_q;
    right  = byp_r_r ? byp_pix_r : lp_r_q;
    up2    = byp_c_r ? byp_ctr_r : lp2_q;
    dx     = $signed({1'b0, right}) - $signed({1'b0, displaced_r});
    dy     = $signed({1'b0, s1_pix_r}) - $signed({1'b0, up2});
    prod_x = dx * dx;
    prod_y = dy * dy;
  end

  // line buffer reads and writes
  always_ff @(posedge clk) begin
    if (accept) begin
      lp_c_q <= line_prev[c0];
      lp_r_q <= line_prev[a_r];
      lp2_q  <= line_prev2[c0];
    end
    if (s1_valid_r) begin
      line_prev[s1_col_r]  <= s1_pix_r;
      line_prev2[s1_col_r] <= center;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r      <= c0;
      s1_pix_r      <= in_luma;
      s1_emit_res_r <= r0 != '0;
      s1_emit_pix_r <= last_row;
      s1_border_r   <= (r0 == 16'd1) || (c0 == '0) || wrap1;
      byp_c_r       <= s1_valid_r && (s1_col_r == c0);
      byp_r_r       <= s1_valid_r && (s1_col_r == a_r);
      byp_pix_r     <= s1_pix_r;
      byp_ctr_r     <= center;
    end
    if (s1_valid_r) begin
      displaced_r   <= center;
      s2_ctr_r      <= center;
      s2_pix_r      <= s1_pix_r;
      s2_sqx_r      <= prod_x[SQ_W-1:0];
      s2_sqy_r      <= prod_y[SQ_W-1:0];
      s2_emit_res_r <= s1_emit_res_r;
      s2_emit_pix_r <= s1_emit_pix_r;
      s2_border_r   <= s1_border_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
    end
  end

  // stage 2: magnitude compare and job push
  logic [MAG_W-1:0] mag;
  logic             is_edge;

  always_comb begin
    mag     = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};
    is_edge = {1'b0, mag} > lim;
    q_push.valid        = s2_valid_r && (s2_emit_res_r || s2_emit_pix_r);
    q_push.job.res      = s2_border_r ? s2_ctr_r : (is_edge ? PIX_EDGE : PIX_FLAT);
    q_push.job.pix      = s2_pix_r;
    q_push.job.emit_res = s2_emit_res_r;
    q_push.job.emit_pix = s2_emit_pix_r;
  end

endmodule

FILE: rtl/gedge_queue.sv
// short job queue between front and back
module gedge_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gedge_pkg::qslot_t         push,
  input  logic                      pop,
  output gedge_pkg::qslot_t         head,
  output logic [gedge_pkg::QCW-1:0] count
);
  import gedge_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r, count_nxt;

  // occupancy update
  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (!push.valid && pop) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  assign head.valid = count_r != '0;
  assign head.job   = mem_r[rd_ptr_r];
  assign count      = count_r;

endmodule

FILE: rtl/gedge_back.sv
// back: splits jobs into results and holds the output register
module gedge_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gedge_pkg::qslot_t           head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gedge_pkg::PIX_W-1:0] out_pixel,
  output logic                        out_last
);
  import gedge_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pixel_r, out_pixel_nxt;
  logic             out_last_r, out_last_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [PIX_W-1:0] pend_pix_r, pend_pix_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // load the output register from the pending pixel or the queue head
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_pixel_nxt  = out_pixel_r;
    out_last_nxt   = out_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_pix_nxt   = pend_pix_r;
    pop            = 1'b0;
    if (slot_free) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_pixel_nxt  = pend_pix_r;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end else if (head.valid) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        if (head.job.emit_res) begin
          out_pixel_nxt  = head.job.res;
          out_last_nxt   = !head.job.emit_pix;
          pend_valid_nxt = head.job.emit_pix;
          pend_pix_nxt   = head.job.pix;
        end else begin
          out_pixel_nxt = head.job.pix;
          out_last_nxt  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
    out_last_r  <= out_last_nxt;
    pend_pix_r  <= pend_pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule

FILE: rtl/gradient_edge_threshold_unit.sv
// Path: the result for the pixel above an input passes stage 1, stage 2, the job queue and
// the output register, and a final-row pixel's own result follows it from the pending register.
// Throughput: one pixel per clock unless the credit check holds in_ready low; in the final row of a
// frame taller than one row two results per pixel share the single output register and slow that row.
// Reset: synchronous active low; counters clear, registers load 640 / 480 / 32.
// The line buffers are not cleared and need no pass after reset.
module gradient_edge_threshold_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  gedge_in_if.sink    in_ch,
  gedge_out_if.source out_ch,
  gedge_cfg_if.sink   cfg_ch
);
  import gedge_pkg::*;

  localparam int WW = width_bits(MAX_WIDTH);

  logic [WW-1:0]    eff_w_r;
  logic [ROW_W-1:0] eff_h_r;
  logic [LIM_W-1:0] lim_r;
  logic [TH_W-1:0]  th;
  logic [2*TH_W-1:0] th_sq;

  // width clamp: zero reads as one, above the buffer depth saturates
  function automatic logic [WW-1:0] eff_width(input logic [FW_W-1:0] fw);
    logic [WW-1:0] f;
    f = WW'(fw);
    if (f == '0) begin
      return WW'(1);
    end
    if (f > WW'(MAX_WIDTH)) begin
      return WW'(MAX_WIDTH);
    end
    return f;
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign th           = cfg_ch.data[TH_W-1:0];
  assign th_sq        = th * th;

  // configuration registers, kept in the form the datapath uses
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= eff_width(FRAME_WIDTH_RST);
      eff_h_r <= FRAME_HEIGHT_RST;
      lim_r   <= LIM_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FRAME_WIDTH: begin
          eff_w_r <= eff_width(cfg_ch.data[FW_W-1:0]);
        end
        REG_FRAME_HEIGHT: begin
          eff_h_r <= (cfg_ch.data == '0) ? ROW_W'(1) : cfg_ch.data[ROW_W-1:0];
        end
        REG_EDGE_THRESHOLD: begin
          lim_r <= {th_sq, 2'b00};
        end
        default: begin
        end
      endcase
    end
  end

  qslot_t         q_push;
  qslot_t         q_head;
  logic           q_pop;
  logic [QCW-1:0] q_count;

  gedge_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .WW        (WW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_luma  (in_ch.luma),
    .eff_w    (eff_w_r),
    .eff_h    (eff_h_r),
    .lim      (lim_r),
    .q_count  (q_count),
    .q_push   (q_push)
  );

  gedge_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .count (q_count)
  );

  gedge_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pixel (out_ch.pixel_out),
    .out_last  (out_ch.run_last)
  );

`ifndef NO_ASSERTIONS
  // credit scheme keeps a free queue slot for every job pushed
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> (q_count < QCW'(QDEPTH)))
    else $error("job pushed into a full queue");

  // a result that is not the last of its pixel is followed at once by the next
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.run_last) |=> out_ch.valid)
    else $error("second result of a pixel not ready after the first");

  // queue level moves only on push or pop
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_push.valid && !q_pop) |=> $stable(q_count))
    else $error("queue level changed without push or pop");
`endif

endmodule

FILE: verif/gradient_edge_threshold_unit_test.sv
`timescale 1ns / 100ps
// testbench for the gradient edge threshold unit: streams gray frames and checks every output pixel
module gradient_edge_threshold_unit_test;
  import gedge_pkg::*;

  localparam int LINE_DEPTH    = 2048;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 150;
  localparam int SETTLE_CYCLES = 12;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             run_last;
  } edge_result_t;

  // tracks frame position and line history, queues the pixels the block owes
  class edge_map_tracker;
    logic [FW_W-1:0]  width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [TH_W-1:0]  thresh_reg;
    logic [PIX_W-1:0] row_above [LINE_DEPTH];
    logic [PIX_W-1:0] row_above2 [LINE_DEPTH];
    logic [PIX_W-1:0] left_above;
    int unsigned      row_idx;
    int unsigned      col_idx;
    edge_result_t     pending_pixels [$];
    int               fails;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      thresh_reg = TH_W'(EDGE_TH_RST);
      foreach (row_above[i]) begin
        row_above[i]  = '0;
        row_above2[i] = '0;
      end
      left_above = '0;
      row_idx    = 0;
      col_idx    = 0;
      fails      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:    width_reg = data[FW_W-1:0];
        REG_FRAME_HEIGHT:   height_reg = data[ROW_W-1:0];
        REG_EDGE_THRESHOLD: thresh_reg = data[TH_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_luma(logic [PIX_W-1:0] luma);
      int unsigned  w, h, r, c;
      int           dx, dy, mag, lim;
      edge_result_t e;
      w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      // a register write may have left the counters past the frame size
      if (col_idx >= w) begin
        col_idx = 0;
        row_idx = (row_idx + 1) & 16'hFFFF;
      end
      if (row_idx >= h) row_idx = 0;
      r = row_idx;
      c = col_idx;
      // pixel one row up now has all four neighbours
      if (r >= 1) begin
        e.pixel = row_above[c];
        if (r > 1 && c > 0 && c + 1 < w) begin
          dx  = int'(row_above[c + 1]) - int'(left_above);
          dy  = int'(luma) - int'(row_above2[c]);
          mag = dx * dx + dy * dy;
          lim = 4 * int'(thresh_reg) * int'(thresh_reg);
          e.pixel = (mag > lim) ? PIX_EDGE : PIX_FLAT;
        end
        e.run_last = (r + 1 < h);
        pending_pixels.push_back(e);
      end
      // final row also passes itself through
      if (r + 1 >= h) begin
        e.pixel    = luma;
        e.run_last = 1'b1;
        pending_pixels.push_back(e);
      end
      // shift the column history
      left_above    = row_above[c];
      row_above2[c] = row_above[c];
      row_above[c]  = luma;
      col_idx = c + 1;
      if (col_idx >= w) begin
        col_idx = 0;
        row_idx = r + 1;
        if (row_idx >= h) row_idx = 0;
      end
    endfunction

    function void check_pixel(logic [PIX_W-1:0] pixel, logic last);
      edge_result_t want;
      if (pending_pixels.size() == 0) begin
        $error("result with nothing expected: pixel_out %0d run_last %0d", pixel, last);
        fails++;
        return;
      end
      want = pending_pixels.pop_front();
      if (pixel !== want.pixel) begin
        $error("pixel_out mismatch: expected %0d, actual %0d", want.pixel, pixel);
        fails++;
      end
      if (last !== want.run_last) begin
        $error("run_last mismatch: expected %0d, actual %0d", want.run_last, last);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycles = 0;
  int          items_sent = 0;

  edge_map_tracker tracker = new();

  gedge_in_if  in_ch ();
  gedge_out_if out_ch ();
  gedge_cfg_if cfg_ch ();

  gradient_edge_threshold_unit #(
    .MAX_WIDTH(LINE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watch every transfer on the three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) tracker.take_luma(in_ch.luma);
      if (out_ch.valid && out_ch.ready) tracker.check_pixel(out_ch.pixel_out, out_ch.run_last);
    end
  end

  function void set_idling(idling_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 46; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default:       begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endfunction

  function automatic int clip_luma(int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  task automatic send_luma(input int v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.luma  <= v[PIX_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // noisy plateau, or near-uniform noise when the spread is wide
  task automatic send_frame(input int w, input int h);
    int base, spread;
    base   = $urandom_range(255);
    spread = ($urandom_range(3) == 0) ? 255 : $urandom_range(40);
    repeat (w * h) send_luma(clip_luma(base + int'($urandom_range(2 * spread)) - spread));
  endtask

  // wait until every owed pixel has left and the pipeline is empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int frame_px [$];
    int rand_start, phase, roll, w_set, h_set, t_set;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.luma   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_FRAME_WIDTH;
    cfg_ch.data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: a full row of 640 and a few pixels into the next,
    // then narrow rows under the reset threshold
    set_idling(IDLE_SENDER);
    send_frame(640, 1);
    send_frame(8, 1);
    settle();
    write_reg(REG_FRAME_WIDTH, 16'd5);
    send_frame(5, 2);
    settle();
    // row counter now beyond the new height, so a fresh frame starts
    write_reg(REG_FRAME_HEIGHT, 16'd4);

    // gradient exactly at the limit, then just above it with negative dx and dy
    set_idling(IDLE_NONE);
    write_reg(REG_FRAME_WIDTH, 16'hF004);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    write_reg(REG_EDGE_THRESHOLD, 16'hAB05);
    frame_px = '{0, 50, 255, 7, 100, 10, 110, 0, 255, 50, 254, 0};
    foreach (frame_px[i]) send_luma(frame_px[i]);
    settle();

    // largest possible gradient stays flat under the top threshold
    write_reg(REG_FRAME_WIDTH, 16'd3);
    write_reg(REG_EDGE_THRESHOLD, 16'h00FF);
    frame_px = '{0, 0, 0, 0, 128, 255, 0, 255, 0};
    foreach (frame_px[i]) send_luma(frame_px[i]);
    settle();

    // zero sizes act as one: every pixel emits only itself
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_FRAME_WIDTH, 16'h0000);
    write_reg(REG_FRAME_HEIGHT, 16'h0000);
    write_reg(REG_EDGE_THRESHOLD, 16'h0000);
    frame_px = '{0, 255, 128};
    foreach (frame_px[i]) send_luma(frame_px[i]);
    settle();

    // oversized width on a single-row frame: a short partial row passes through
    set_idling(IDLE_RECEIVER);
    write_reg(REG_FRAME_WIDTH, 16'hFFFF);
    write_reg(REG_FRAME_HEIGHT, 16'd1);
    write_reg(REG_EDGE_THRESHOLD, 16'($urandom_range(80)));
    send_frame(24, 1);
    settle();

    // tallest frame, cut short by shrinking width mid-row and then height
    set_idling(IDLE_BOTH);
    write_reg(REG_FRAME_WIDTH, 16'd6);
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    send_frame(6, 2);
    send_frame(4, 1);
    settle();
    write_reg(REG_FRAME_WIDTH, 16'd3);
    send_frame(3, 2);
    settle();
    write_reg(REG_FRAME_HEIGHT, 16'd4);
    send_frame(3, 4);
    settle();

    // random geometries and thresholds, whole frames per setting
    rand_start = items_sent;
    phase = 0;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      set_idling(idling_t'(phase % 4));
      phase++;
      roll  = $urandom_range(99);
      w_set = (roll < 5) ? 0 : ((roll < 80) ? $urandom_range(1, 12) : $urandom_range(13, 20));
      roll  = $urandom_range(99);
      h_set = (roll < 5) ? 0 : ((roll < 20) ? 1 : $urandom_range(2, 5));
      roll  = $urandom_range(99);
      t_set = (roll < 10) ? 0 : ((roll < 20) ? 255 : $urandom_range(90));
      write_reg(REG_FRAME_WIDTH, {4'($urandom), 12'(w_set)});
      write_reg(REG_FRAME_HEIGHT, 16'(h_set));
      if ($urandom_range(3) != 0) write_reg(REG_EDGE_THRESHOLD, {8'($urandom), 8'(t_set)});
      repeat ($urandom_range(1, 3)) send_frame((w_set == 0) ? 1 : w_set, (h_set == 0) ? 1 : h_set);
      settle();
    end

    settle();
    if (tracker.fails == 0 && tracker.pending_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
